// ----- rtl/iqbb_pkg.sv -----
package iqbb_pkg;

	// register map, word index = paddr[3:2]
	localparam logic [1:0] REG_LEVEL_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_EDGE_MARGIN     = 2'd1;
	localparam logic [1:0] REG_RUN_LENGTH      = 2'd2;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	// reset values
	localparam logic [15:0] THRESHOLD_RST = 16'd200;
	localparam logic [11:0] MARGIN_RST    = 12'd20;
	localparam logic [3:0]  RUN_LEN_RST   = 4'd5;

	// shortest burst that can report a region
	localparam int unsigned MIN_BURST = 5;

	// widths of the fixed result fields
	localparam int unsigned START_W = 12;
	localparam int unsigned LEN_W   = 13;

	typedef struct packed {
		logic [15:0] level_threshold;
		logic [11:0] edge_margin;
		logic [3:0]  run_length;
	} cfg_t;

	// one classified sample between level stage and run tracker
	typedef struct packed {
		logic valid;
		logic active;
		logic last;
	} sample_t;

endpackage

// ----- rtl/iqbb_regs.sv -----
module iqbb_regs (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [iqbb_pkg::ADDR_W-1:0]    paddr,
	input  logic [iqbb_pkg::DATA_W-1:0]    pwdata,
	output logic [iqbb_pkg::DATA_W-1:0]    prdata,
	output logic                           pready,
	output iqbb_pkg::cfg_t                 cfg
);
	import iqbb_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_sel;

	assign pready  = 1'b1;
	assign reg_sel = paddr[3:2];
	assign wr_en   = psel & penable & pwrite & pready;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.level_threshold <= THRESHOLD_RST;
			cfg_q.edge_margin     <= MARGIN_RST;
			cfg_q.run_length      <= RUN_LEN_RST;
		end else if (wr_en) begin
			unique case (reg_sel)
				REG_LEVEL_THRESHOLD: cfg_q.level_threshold <= pwdata[15:0];
				REG_EDGE_MARGIN:     cfg_q.edge_margin     <= pwdata[11:0];
				REG_RUN_LENGTH:      cfg_q.run_length      <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_sel)
			REG_LEVEL_THRESHOLD: prdata = {16'd0, cfg_q.level_threshold};
			REG_EDGE_MARGIN:     prdata = {20'd0, cfg_q.edge_margin};
			REG_RUN_LENGTH:      prdata = {28'd0, cfg_q.run_length};
			default:             prdata = '0;
		endcase
	end

endmodule

// ----- rtl/iqbb_level.sv -----
module iqbb_level (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [15:0]      in_i,
	input  logic signed [15:0]      in_q,
	input  logic                    in_last,
	input  logic [15:0]             level_threshold,
	output iqbb_pkg::sample_t       smp,
	input  logic                    smp_ready
);
	import iqbb_pkg::*;

	logic               valid_s1;
	logic signed [15:0] i_s1;
	logic signed [15:0] q_s1;
	logic               last_s1;
	sample_t            smp_s2;

	logic        ready_s1;
	logic        ready_s2;
	logic [16:0] mag_i;
	logic [16:0] mag_q;
	logic        active;

	assign ready_s2 = !smp_s2.valid || smp_ready;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_ready = ready_s1;
	assign smp      = smp_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			i_s1    <= in_i;
			q_s1    <= in_q;
			last_s1 <= in_last;
		end
	end

	// magnitudes, 17 bits so that -32768 stays positive
	always_comb begin
		mag_i  = i_s1[15] ? 17'd0 - {i_s1[15], i_s1} : {1'b0, i_s1};
		mag_q  = q_s1[15] ? 17'd0 - {q_s1[15], q_s1} : {1'b0, q_s1};
		active = (mag_i >= {1'b0, level_threshold}) || (mag_q >= {1'b0, level_threshold});
	end

	// classified sample register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			smp_s2 <= '0;
		end else if (ready_s2) begin
			smp_s2.valid  <= valid_s1;
			smp_s2.active <= active;
			smp_s2.last   <= last_s1;
		end
	end

endmodule

// ----- rtl/iqbb_tracker.sv -----
module iqbb_tracker #(
	parameter int unsigned MAX_SAMPLES = 4096,
	parameter int unsigned CNT_W       = 13,
	parameter int unsigned IDX_W       = 12
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  iqbb_pkg::sample_t    smp,
	output logic                 smp_ready,
	input  logic [3:0]           run_length,
	output logic                 snap_valid,
	input  logic                 snap_ready,
	output logic                 seen_s3,
	output logic [IDX_W-1:0]     first_end_s3,
	output logic [IDX_W-1:0]     last_end_s3,
	output logic [CNT_W-1:0]     count_s3
);
	import iqbb_pkg::*;

	logic [CNT_W-1:0] count_q;
	logic [3:0]       run_q;
	logic             seen_q;
	logic [IDX_W-1:0] first_end_q;
	logic [IDX_W-1:0] last_end_q;
	logic             valid_s3;

	logic [3:0]       rl;
	logic             countable;
	logic [IDX_W-1:0] idx;
	logic [3:0]       run_nxt;
	logic             hit;
	logic [CNT_W-1:0] count_nxt;
	logic             seen_nxt;
	logic [IDX_W-1:0] first_nxt;
	logic [IDX_W-1:0] last_nxt;
	logic             take;

	assign smp_ready  = !(smp.valid && smp.last) || !valid_s3 || snap_ready;
	assign take       = smp.valid && smp_ready;
	assign snap_valid = valid_s3;

	// run state after this sample
	always_comb begin
		rl        = (run_length == 4'd0) ? 4'd1 : run_length;
		countable = count_q < CNT_W'(MAX_SAMPLES);
		idx       = count_q[IDX_W-1:0];
		count_nxt = count_q;
		run_nxt   = run_q;
		seen_nxt  = seen_q;
		first_nxt = first_end_q;
		last_nxt  = last_end_q;
		hit       = 1'b0;
		if (countable) begin
			if (smp.active) begin
				run_nxt = (run_q < 4'd15) ? run_q + 4'd1 : run_q;
			end else begin
				run_nxt = 4'd0;
			end
			hit = smp.active && (run_nxt >= rl);
			if (hit) begin
				if (!seen_q) begin
					first_nxt = idx;
				end
				seen_nxt = 1'b1;
				last_nxt = idx;
			end
			count_nxt = count_q + CNT_W'(1);
		end
	end

	// burst state, cleared after the final sample
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			run_q       <= '0;
			seen_q      <= 1'b0;
			first_end_q <= '0;
			last_end_q  <= '0;
		end else if (take) begin
			if (smp.last) begin
				count_q     <= '0;
				run_q       <= '0;
				seen_q      <= 1'b0;
				first_end_q <= '0;
				last_end_q  <= '0;
			end else begin
				count_q     <= count_nxt;
				run_q       <= run_nxt;
				seen_q      <= seen_nxt;
				first_end_q <= first_nxt;
				last_end_q  <= last_nxt;
			end
		end
	end

	// end-of-burst snapshot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (take && smp.last) begin
			valid_s3 <= 1'b1;
		end else if (snap_ready) begin
			valid_s3 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && smp.last) begin
			seen_s3      <= seen_nxt;
			first_end_s3 <= first_nxt;
			last_end_s3  <= last_nxt;
			count_s3     <= count_nxt;
		end
	end

endmodule

// ----- rtl/iqbb_bounds.sv -----
module iqbb_bounds #(
	parameter int unsigned CNT_W = 13,
	parameter int unsigned IDX_W = 12
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               snap_valid,
	output logic                               snap_ready,
	input  logic                               seen,
	input  logic [IDX_W-1:0]                   first_end,
	input  logic [IDX_W-1:0]                   last_end,
	input  logic [CNT_W-1:0]                   count,
	input  logic [3:0]                         run_length,
	input  logic [11:0]                        edge_margin,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [iqbb_pkg::START_W-1:0]       start_index,
	output logic [iqbb_pkg::LEN_W-1:0]         region_length
);
	import iqbb_pkg::*;

	// wide enough for last_end + margin and any count
	localparam int unsigned CW = ((CNT_W > 12) ? CNT_W : 12) + 1;

	logic          valid_q;
	logic          found_q;
	logic [START_W-1:0] start_q;
	logic [LEN_W-1:0]   len_q;

	logic [3:0]    rl;
	logic [CW-1:0] first_p1;
	logic [CW-1:0] run_start;
	logic [CW-1:0] margin;
	logic [CW-1:0] start;
	logic [CW-1:0] end_raw;
	logic [CW-1:0] end_clip;
	logic [CW-1:0] len;
	logic          hit;

	assign snap_ready    = !valid_q || out_ready;
	assign out_valid     = valid_q;
	assign found         = found_q;
	assign start_index   = start_q;
	assign region_length = len_q;

	// region bounds from the burst snapshot
	always_comb begin
		rl        = (run_length == 4'd0) ? 4'd1 : run_length;
		margin    = CW'(edge_margin);
		first_p1  = CW'(first_end) + CW'(1);
		run_start = (first_p1 >= CW'(rl)) ? first_p1 - CW'(rl) : '0;
		start     = (run_start > margin) ? run_start - margin : '0;
		end_raw   = CW'(last_end) + margin;
		end_clip  = (end_raw > CW'(count)) ? CW'(count) : end_raw;
		hit       = seen && (count >= CNT_W'(MIN_BURST)) && (end_clip > start);
		len       = end_clip - start;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (snap_ready) begin
			valid_q <= snap_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (snap_ready && snap_valid) begin
			found_q <= hit;
			start_q <= hit ? start[START_W-1:0] : '0;
			len_q   <= hit ? len[LEN_W-1:0] : '0;
		end
	end

endmodule

// ----- rtl/iq_burst_bounds_detector.sv -----
// Channel   Dir  Signals                          Moves
// s_*       in   tvalid tready tdata tlast        one I/Q sample request, tlast ends the burst
// m_*       out  tvalid tready tdata tuser        one region request per burst
// apb       in   psel penable pwrite paddr ...    threshold, margin, run length
//
// One sample is taken every cycle while s_tready is high. m_tvalid rises once a burst's final
// sample has passed the input register, classified sample, tracker snapshot and result register.
// Reset clears the burst state and loads the register defaults (200, 20, 5).
// While m_tready is low the result holds and a second finished burst waits in the snapshot
// stage; samples keep flowing until the next final sample reaches the tracker, then the
// stages behind it fill and s_tready drops.
module iq_burst_bounds_detector #(
	parameter int unsigned MAX_SAMPLES = 4096
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// slave: [15:0] in_i, [31:16] in_q
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [31:0]                   s_tdata,
	input  logic                          s_tlast,
	// master: [11:0] start_index, [24:12] region_length, [31:25] zero
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [31:0]                   m_tdata,
	// master: [0] found
	output logic                          m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [iqbb_pkg::ADDR_W-1:0]   paddr,
	input  logic [iqbb_pkg::DATA_W-1:0]   pwdata,
	output logic [iqbb_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import iqbb_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_SAMPLES + 1);
	localparam int unsigned IDX_W = $clog2(MAX_SAMPLES);

	cfg_t               cfg;
	sample_t            smp;
	logic               smp_ready;
	logic               snap_valid;
	logic               snap_ready;
	logic               seen;
	logic [IDX_W-1:0]   first_end;
	logic [IDX_W-1:0]   last_end;
	logic [CNT_W-1:0]   count;
	logic [START_W-1:0] start_index;
	logic [LEN_W-1:0]   region_length;

	assign m_tdata = {7'd0, region_length, start_index};

	iqbb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	iqbb_level u_level (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.in_i            (s_tdata[15:0]),
		.in_q            (s_tdata[31:16]),
		.in_last         (s_tlast),
		.level_threshold (cfg.level_threshold),
		.smp             (smp),
		.smp_ready       (smp_ready)
	);

	iqbb_tracker #(
		.MAX_SAMPLES (MAX_SAMPLES),
		.CNT_W       (CNT_W),
		.IDX_W       (IDX_W)
	) u_tracker (
		.clk          (clk),
		.arst_n       (arst_n),
		.smp          (smp),
		.smp_ready    (smp_ready),
		.run_length   (cfg.run_length),
		.snap_valid   (snap_valid),
		.snap_ready   (snap_ready),
		.seen_s3      (seen),
		.first_end_s3 (first_end),
		.last_end_s3  (last_end),
		.count_s3     (count)
	);

	iqbb_bounds #(
		.CNT_W (CNT_W),
		.IDX_W (IDX_W)
	) u_bounds (
		.clk           (clk),
		.arst_n        (arst_n),
		.snap_valid    (snap_valid),
		.snap_ready    (snap_ready),
		.seen          (seen),
		.first_end     (first_end),
		.last_end      (last_end),
		.count         (count),
		.run_length    (cfg.run_length),
		.edge_margin   (cfg.edge_margin),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.found         (m_tuser),
		.start_index   (start_index),
		.region_length (region_length)
	);

endmodule
